>>> rtl/qwpm_pkg.sv
// shared constants and register codes of the quality weighted pixel mixer
package qwpm_pkg;

   localparam int CH                 = 4;
   localparam int WEIGHT_BITS        = 8;
   localparam int COEFF_BITS         = 9;
   localparam int COUNT_BITS         = 3;
   localparam int SUM_BITS           = 16;
   localparam int DEFAULT_VALUE_BITS = 16;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [COEFF_BITS-1:0] ONE_Q8        = 9'd256;
   localparam logic [COEFF_BITS-1:0] COEFF_RESET   = 9'd128;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET   = 3'd1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MIX_COEFF     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 1'b1;

endpackage

>>> rtl/qwpm_req_if.sv
// request and response channel interfaces of the pixel mixer
interface qwpm_req_if #(
   parameter int VALUE_BITS = qwpm_pkg::DEFAULT_VALUE_BITS
);
   logic                                valid;
   logic                                ready;
   logic [qwpm_pkg::WEIGHT_BITS-1:0]    src_weight;
   logic [qwpm_pkg::WEIGHT_BITS-1:0]    dst_weight;
   logic [VALUE_BITS-1:0]               src_value_0;
   logic [VALUE_BITS-1:0]               src_value_1;
   logic [VALUE_BITS-1:0]               src_value_2;
   logic [VALUE_BITS-1:0]               src_value_3;
   logic [VALUE_BITS-1:0]               dst_value_0;
   logic [VALUE_BITS-1:0]               dst_value_1;
   logic [VALUE_BITS-1:0]               dst_value_2;
   logic [VALUE_BITS-1:0]               dst_value_3;

   modport source (output valid, src_weight, dst_weight, src_value_0, src_value_1,
                   src_value_2, src_value_3, dst_value_0, dst_value_1, dst_value_2,
                   dst_value_3, input ready);
   modport sink (input valid, src_weight, dst_weight, src_value_0, src_value_1,
                 src_value_2, src_value_3, dst_value_0, dst_value_1, dst_value_2,
                 dst_value_3, output ready);
endinterface

interface qwpm_rsp_if #(
   parameter int VALUE_BITS = qwpm_pkg::DEFAULT_VALUE_BITS
);
   logic                                valid;
   logic                                ready;
   logic [VALUE_BITS-1:0]               mixed_value_0;
   logic [VALUE_BITS-1:0]               mixed_value_1;
   logic [VALUE_BITS-1:0]               mixed_value_2;
   logic [VALUE_BITS-1:0]               mixed_value_3;
   logic [qwpm_pkg::WEIGHT_BITS-1:0]    mixed_weight;
   logic                                updated;

   modport source (output valid, mixed_value_0, mixed_value_1, mixed_value_2,
                   mixed_value_3, mixed_weight, updated, input ready);
   modport sink (input valid, mixed_value_0, mixed_value_1, mixed_value_2,
                 mixed_value_3, mixed_weight, updated, output ready);
endinterface

>>> rtl/qwpm_front.sv
// weight scaling, channel products and divider setup (three stages)
module qwpm_front #(
   parameter int VALUE_BITS = qwpm_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   qwpm_req_if.sink                           req_ch,
   input  logic [qwpm_pkg::COEFF_BITS-1:0]    mix_coeff,
   input  logic [qwpm_pkg::COUNT_BITS-1:0]    channel_count,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [qwpm_pkg::SUM_BITS-1:0]      rem_o [qwpm_pkg::CH],
   output logic [VALUE_BITS-1:0]              nq_o  [qwpm_pkg::CH],
   output logic [qwpm_pkg::SUM_BITS-1:0]      div_o [qwpm_pkg::CH],
   output logic [qwpm_pkg::WEIGHT_BITS-1:0]   weight_o,
   output logic                               upd_o
);
   import qwpm_pkg::*;

   localparam int PW = SUM_BITS + VALUE_BITS;

   // stage a
   logic [COEFF_BITS-1:0]  coeff;
   logic [SUM_BITS-1:0]    s_a_in, d_a_in, sum_a_in;
   logic                   mix_a_in;
   logic [CH-1:0]          act_a_in;
   logic [VALUE_BITS-1:0]  sv_a_in [CH];
   logic [VALUE_BITS-1:0]  dv_a_in [CH];

   logic                   va_ff;
   logic [SUM_BITS-1:0]    s_a_ff, d_a_ff, sum_a_ff;
   logic                   mix_a_ff;
   logic [CH-1:0]          act_a_ff;
   logic [VALUE_BITS-1:0]  sv_a_ff [CH];
   logic [VALUE_BITS-1:0]  dv_a_ff [CH];
   logic [WEIGHT_BITS-1:0] wd_a_ff;

   // stage b
   logic                   vb_ff;
   logic [PW-1:0]          ps_b_ff [CH];
   logic [PW-1:0]          pd_b_ff [CH];
   logic [SUM_BITS-1:0]    sum_b_ff;
   logic                   mix_b_ff;
   logic [CH-1:0]          act_b_ff;
   logic [VALUE_BITS-1:0]  dv_b_ff [CH];
   logic [WEIGHT_BITS-1:0] weight_b_ff;

   // stage c
   logic                   vc_ff;
   logic [PW-1:0]          num_c [CH];

   logic load_a, load_b, load_c;

   assign load_c       = !vc_ff || out_ready;
   assign load_b       = !vb_ff || load_c;
   assign load_a       = !va_ff || load_b;
   assign req_ch.ready = load_a;
   assign out_valid    = vc_ff;

   always_comb begin
      coeff    = (mix_coeff > ONE_Q8) ? ONE_Q8 : mix_coeff;
      s_a_in   = SUM_BITS'(17'(req_ch.src_weight) * 17'(coeff));
      d_a_in   = SUM_BITS'(17'(req_ch.dst_weight) * 17'(ONE_Q8 - coeff));
      sum_a_in = s_a_in + d_a_in;
      mix_a_in = ((req_ch.src_weight != '0) || (req_ch.dst_weight != '0))
                 && (sum_a_in != '0);
      for (int k = 0; k < CH; k++) begin
         act_a_in[k] = mix_a_in && (COUNT_BITS'(k) < channel_count);
      end
      sv_a_in[0] = req_ch.src_value_0;
      sv_a_in[1] = req_ch.src_value_1;
      sv_a_in[2] = req_ch.src_value_2;
      sv_a_in[3] = req_ch.src_value_3;
      dv_a_in[0] = req_ch.dst_value_0;
      dv_a_in[1] = req_ch.dst_value_1;
      dv_a_in[2] = req_ch.dst_value_2;
      dv_a_in[3] = req_ch.dst_value_3;
   end

   always_comb begin
      for (int k = 0; k < CH; k++) begin
         num_c[k] = ps_b_ff[k] + pd_b_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (load_a) va_ff <= req_ch.valid;
         if (load_b) vb_ff <= va_ff;
         if (load_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         s_a_ff   <= s_a_in;
         d_a_ff   <= d_a_in;
         sum_a_ff <= sum_a_in;
         mix_a_ff <= mix_a_in;
         act_a_ff <= act_a_in;
         sv_a_ff  <= sv_a_in;
         dv_a_ff  <= dv_a_in;
         wd_a_ff  <= req_ch.dst_weight;
      end
      if (load_b) begin
         for (int k = 0; k < CH; k++) begin
            ps_b_ff[k] <= PW'(s_a_ff) * PW'(sv_a_ff[k]);
            pd_b_ff[k] <= PW'(d_a_ff) * PW'(dv_a_ff[k]);
         end
         sum_b_ff    <= sum_a_ff;
         mix_b_ff    <= mix_a_ff;
         act_b_ff    <= act_a_ff;
         dv_b_ff     <= dv_a_ff;
         weight_b_ff <= mix_a_ff ? sum_a_ff[SUM_BITS-1 -: WEIGHT_BITS] : wd_a_ff;
      end
      if (load_c) begin
         // a pass-through channel divides its destination value by one
         for (int k = 0; k < CH; k++) begin
            if (act_b_ff[k]) begin
               rem_o[k] <= num_c[k][PW-1 -: SUM_BITS];
               nq_o[k]  <= num_c[k][VALUE_BITS-1:0];
               div_o[k] <= sum_b_ff;
            end else begin
               rem_o[k] <= '0;
               nq_o[k]  <= dv_b_ff[k];
               div_o[k] <= SUM_BITS'(1);
            end
         end
         weight_o <= weight_b_ff;
         upd_o    <= mix_b_ff;
      end
   end

endmodule

>>> rtl/qwpm_div_stage.sv
// one restoring division step for all channels, one quotient bit per stage
module qwpm_div_stage #(
   parameter int VALUE_BITS = qwpm_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [qwpm_pkg::SUM_BITS-1:0]      rem_i [qwpm_pkg::CH],
   input  logic [VALUE_BITS-1:0]              nq_i  [qwpm_pkg::CH],
   input  logic [qwpm_pkg::SUM_BITS-1:0]      div_i [qwpm_pkg::CH],
   input  logic [qwpm_pkg::WEIGHT_BITS-1:0]   weight_i,
   input  logic                               upd_i,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [qwpm_pkg::SUM_BITS-1:0]      rem_o [qwpm_pkg::CH],
   output logic [VALUE_BITS-1:0]              nq_o  [qwpm_pkg::CH],
   output logic [qwpm_pkg::SUM_BITS-1:0]      div_o [qwpm_pkg::CH],
   output logic [qwpm_pkg::WEIGHT_BITS-1:0]   weight_o,
   output logic                               upd_o
);
   import qwpm_pkg::*;

   logic                  v_ff;
   logic                  load;
   logic [SUM_BITS:0]     trial [CH];
   logic [CH-1:0]         ge;
   logic [SUM_BITS-1:0]   rem_in [CH];
   logic [VALUE_BITS-1:0] nq_in  [CH];

   assign load      = !v_ff || out_ready;
   assign in_ready  = load;
   assign out_valid = v_ff;

   always_comb begin
      for (int k = 0; k < CH; k++) begin
         trial[k]  = {rem_i[k], nq_i[k][VALUE_BITS-1]};
         ge[k]     = trial[k] >= {1'b0, div_i[k]};
         rem_in[k] = ge[k] ? SUM_BITS'(trial[k] - {1'b0, div_i[k]})
                           : trial[k][SUM_BITS-1:0];
         nq_in[k]  = {nq_i[k][VALUE_BITS-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (load) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_o    <= rem_in;
         nq_o     <= nq_in;
         div_o    <= div_i;
         weight_o <= weight_i;
         upd_o    <= upd_i;
      end
   end

endmodule

>>> rtl/quality_weighted_pixel_mixer_top.sv
// top level of the quality weighted pixel mixer
//
//  channel   direction  handshake     word
//  req_ch    in         valid/ready   two weights, four source and four destination values
//  rsp_ch    out        valid/ready   four mixed values, mixed weight, updated flag
//  csr_*     in         write enable  register index and data, no read-back
//
// one word per cycle sustained while the response side stays ready; the path runs through three
// front stages, then one divider stage per quotient bit
// reset is synchronous and active high; it empties the pipe and restores the
// registers to coefficient one half and one channel
// each stage holds its word while the next one stalls, so bubbles fill up and
// nothing is lost or repeated
module quality_weighted_pixel_mixer_top #(
   parameter int VALUE_BITS = qwpm_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   qwpm_req_if.sink                               req_ch,
   qwpm_rsp_if.source                             rsp_ch,
   input  logic                                   csr_write_en,
   input  logic [qwpm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [qwpm_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import qwpm_pkg::*;

   localparam int NS = VALUE_BITS;

   // configuration registers
   logic [COEFF_BITS-1:0] mix_coeff_ff;
   logic [COUNT_BITS-1:0] channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_coeff_ff     <= COEFF_RESET;
         channel_count_ff <= COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MIX_COEFF:     mix_coeff_ff     <= csr_data[COEFF_BITS-1:0];
            REG_CHANNEL_COUNT: channel_count_ff <= csr_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // links between stages, index 0 is the front output
   logic                   vld   [NS+1];
   logic                   rdy   [NS+1];
   logic [SUM_BITS-1:0]    rem   [NS+1][CH];
   logic [VALUE_BITS-1:0]  nq    [NS+1][CH];
   logic [SUM_BITS-1:0]    dvs   [NS+1][CH];
   logic [WEIGHT_BITS-1:0] wgt   [NS+1];
   logic                   upd   [NS+1];

   qwpm_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .mix_coeff     (mix_coeff_ff),
      .channel_count (channel_count_ff),
      .out_valid     (vld[0]),
      .out_ready     (rdy[0]),
      .rem_o         (rem[0]),
      .nq_o          (nq[0]),
      .div_o         (dvs[0]),
      .weight_o      (wgt[0]),
      .upd_o         (upd[0])
   );

   // divider pipe: one quotient bit per stage, msb first
   for (genvar i = 0; i < NS; i++) begin : g_div
      qwpm_div_stage #(.VALUE_BITS(VALUE_BITS)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[i]),
         .in_ready  (rdy[i]),
         .rem_i     (rem[i]),
         .nq_i      (nq[i]),
         .div_i     (dvs[i]),
         .weight_i  (wgt[i]),
         .upd_i     (upd[i]),
         .out_valid (vld[i+1]),
         .out_ready (rdy[i+1]),
         .rem_o     (rem[i+1]),
         .nq_o      (nq[i+1]),
         .div_o     (dvs[i+1]),
         .weight_o  (wgt[i+1]),
         .upd_o     (upd[i+1])
      );
   end

   // last stage register is the output register
   assign rdy[NS]              = rsp_ch.ready;
   assign rsp_ch.valid         = vld[NS];
   assign rsp_ch.mixed_value_0 = nq[NS][0];
   assign rsp_ch.mixed_value_1 = nq[NS][1];
   assign rsp_ch.mixed_value_2 = nq[NS][2];
   assign rsp_ch.mixed_value_3 = nq[NS][3];
   assign rsp_ch.mixed_weight  = wgt[NS];
   assign rsp_ch.updated       = upd[NS];

endmodule

>>> dv/tb_qwpm_mix_checker.sv
// checker for the pixel mixer: follows the register writes, predicts each word and compares
`timescale 1ns / 1ps

module tb_qwpm_mix_checker #(
   parameter int VALUE_BITS = qwpm_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   qwpm_req_if                                 req_mon,
   qwpm_rsp_if                                 rsp_mon,
   input  logic                                csr_write_en,
   input  logic [qwpm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [qwpm_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                  mismatch_count,
   output int                                  pixels_in_flight
);
   import qwpm_pkg::*;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  value_0;
      logic [VALUE_BITS-1:0]  value_1;
      logic [VALUE_BITS-1:0]  value_2;
      logic [VALUE_BITS-1:0]  value_3;
      logic [WEIGHT_BITS-1:0] weight;
      logic                   updated;
   } mixed_pixel_t;

   logic [COEFF_BITS-1:0] coeff_copy;
   logic [COUNT_BITS-1:0] count_copy;
   mixed_pixel_t          mixed_queue[$];

   function automatic mixed_pixel_t blend_pixel(
      input logic [WEIGHT_BITS-1:0] ws, input logic [WEIGHT_BITS-1:0] wd,
      input logic [4*VALUE_BITS-1:0] src_vals, input logic [4*VALUE_BITS-1:0] dst_vals);
      mixed_pixel_t          res;
      logic [63:0]           coeff;
      logic [63:0]           s_part;
      logic [63:0]           d_part;
      logic [63:0]           total;
      logic [63:0]           quot;
      logic [VALUE_BITS-1:0] lane [4];
      logic                  do_mix;
      coeff = (coeff_copy > ONE_Q8) ? 64'(ONE_Q8) : 64'(coeff_copy);
      s_part = 64'(ws) * coeff;
      d_part = 64'(wd) * (64'(ONE_Q8) - coeff);
      total = s_part + d_part;
      // a zero scaled sum counts as no update
      do_mix = (ws != 0 || wd != 0) && total != 0;
      for (int k = 0; k < CH; k++) begin
         lane[k] = dst_vals[k*VALUE_BITS +: VALUE_BITS];
         if (do_mix && k < count_copy) begin
            quot = (s_part * 64'(src_vals[k*VALUE_BITS +: VALUE_BITS])
                    + d_part * 64'(dst_vals[k*VALUE_BITS +: VALUE_BITS])) / total;
            lane[k] = quot[VALUE_BITS-1:0];
         end
      end
      res.value_0 = lane[0];
      res.value_1 = lane[1];
      res.value_2 = lane[2];
      res.value_3 = lane[3];
      res.weight  = do_mix ? total[15:8] : wd;
      res.updated = do_mix;
      return res;
   endfunction

   always @(posedge clock) begin
      mixed_pixel_t want;
      mixed_pixel_t got;
      if (reset) begin
         coeff_copy <= COEFF_RESET;
         count_copy <= COUNT_RESET;
         mixed_queue.delete();
         mismatch_count <= 0;
         pixels_in_flight <= 0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == REG_MIX_COEFF) coeff_copy <= csr_data[COEFF_BITS-1:0];
            else if (csr_index == REG_CHANNEL_COUNT) count_copy <= csr_data[COUNT_BITS-1:0];
         end
         if (req_mon.valid && req_mon.ready)
            mixed_queue.push_back(blend_pixel(req_mon.src_weight, req_mon.dst_weight,
               {req_mon.src_value_3, req_mon.src_value_2, req_mon.src_value_1,
                req_mon.src_value_0},
               {req_mon.dst_value_3, req_mon.dst_value_2, req_mon.dst_value_1,
                req_mon.dst_value_0}));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.mixed_value_0, rsp_mon.mixed_value_1, rsp_mon.mixed_value_2,
                   rsp_mon.mixed_value_3, rsp_mon.mixed_weight, rsp_mon.updated};
            if (mixed_queue.size() == 0) begin
               $display("%0t: unexpected word, actual %h", $time, got);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = mixed_queue.pop_front();
               if (want != got) begin
                  $display("%0t: mismatch v0 %h/%h v1 %h/%h v2 %h/%h v3 %h/%h w %h/%h u %b/%b",
                     $time, want.value_0, got.value_0, want.value_1, got.value_1,
                     want.value_2, got.value_2, want.value_3, got.value_3,
                     want.weight, got.weight, want.updated, got.updated);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         pixels_in_flight <= mixed_queue.size();
      end
   end

endmodule

>>> dv/tb_quality_weighted_pixel_mixer_top.sv
// top of the pixel mixer testbench: clock, reset, stimulus phases and verdict
`timescale 1ns / 1ps

module tb_quality_weighted_pixel_mixer_top;
   import qwpm_pkg::*;

   localparam int VALUE_BITS  = DEFAULT_VALUE_BITS;
   localparam int PIPE_DEPTH  = 3 + VALUE_BITS;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES      = 8;
   localparam int RANDOM_PER_PHASE = 225;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int mismatch_count;
   int pixels_in_flight;
   int cycle_count = 0;
   int sender_idle_pct;
   int receiver_stall_pct;
   bit holdoff_wanted;
   int pixels_sent;

   qwpm_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   qwpm_rsp_if #(.VALUE_BITS(VALUE_BITS)) rsp_ch ();

   quality_weighted_pixel_mixer_top #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data)
   );

   tb_qwpm_mix_checker #(.VALUE_BITS(VALUE_BITS)) mix_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_data(csr_data),
      .mismatch_count(mismatch_count), .pixels_in_flight(pixels_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop if the pipe hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver side: random stalls, plus one long hold-off so the pipe backs up
   initial begin
      int holdoff_left;
      bit holdoff_done;
      holdoff_left = 0;
      holdoff_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_wanted && !holdoff_done) begin
            holdoff_done = 1;
            holdoff_left = 300;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // one register write, idle pipe only
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int unsigned val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // offer one word and hold it until taken, then maybe leave a gap
   task automatic send_pixel(input logic [7:0] ws, input logic [7:0] wd,
                             input logic [4*VALUE_BITS-1:0] sv,
                             input logic [4*VALUE_BITS-1:0] dv);
      req_ch.valid       <= 1'b1;
      req_ch.src_weight  <= ws;
      req_ch.dst_weight  <= wd;
      req_ch.src_value_0 <= sv[0*VALUE_BITS +: VALUE_BITS];
      req_ch.src_value_1 <= sv[1*VALUE_BITS +: VALUE_BITS];
      req_ch.src_value_2 <= sv[2*VALUE_BITS +: VALUE_BITS];
      req_ch.src_value_3 <= sv[3*VALUE_BITS +: VALUE_BITS];
      req_ch.dst_value_0 <= dv[0*VALUE_BITS +: VALUE_BITS];
      req_ch.dst_value_1 <= dv[1*VALUE_BITS +: VALUE_BITS];
      req_ch.dst_value_2 <= dv[2*VALUE_BITS +: VALUE_BITS];
      req_ch.dst_value_3 <= dv[3*VALUE_BITS +: VALUE_BITS];
      // ready only moves on a rising edge, so the falling edge sees what the next edge sees
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
      pixels_sent++;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [7:0] pick_weight();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [4*VALUE_BITS-1:0] pick_values();
      logic [4*VALUE_BITS-1:0] vals;
      for (int k = 0; k < 4; k++)
         case ($urandom_range(9))
            0: vals[k*VALUE_BITS +: VALUE_BITS] = '0;
            1: vals[k*VALUE_BITS +: VALUE_BITS] = '1;
            default: vals[k*VALUE_BITS +: VALUE_BITS] = VALUE_BITS'($urandom);
         endcase
      return vals;
   endfunction

   // wait for every word to come back, then let the pipe settle
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pixels_in_flight != 0);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   initial begin
      int unsigned phase_coeff [PHASES];
      int unsigned phase_count [PHASES];
      phase_coeff = '{0, 256, 511, 1, 255, 64, 200, 128};
      phase_count = '{4, 4, 2, 3, 0, 7, 5, 1};
      pixels_sent = 0;
      holdoff_wanted = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.src_weight = '0;
      req_ch.dst_weight = '0;
      req_ch.src_value_0 = '0;
      req_ch.src_value_1 = '0;
      req_ch.src_value_2 = '0;
      req_ch.src_value_3 = '0;
      req_ch.dst_value_0 = '0;
      req_ch.dst_value_1 = '0;
      req_ch.dst_value_2 = '0;
      req_ch.dst_value_3 = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words under the reset settings: half coefficient, one channel
      send_pixel(8'd0, 8'd0, '1, '0);
      send_pixel(8'd255, 8'd255, '1, '0);
      send_pixel(8'd255, 8'd0, '1, '1);
      send_pixel(8'd0, 8'd255, '0, '1);
      send_pixel(8'd1, 8'd1, {4{16'hffff}}, {4{16'h0001}});
      send_pixel(8'd128, 8'd3, {4{16'h5555}}, {4{16'haaaa}});
      settle();

      // coefficient zero gives the source no share: zero scaled sum when the destination is empty
      write_reg(REG_MIX_COEFF, 0);
      write_reg(REG_CHANNEL_COUNT, 4);
      send_pixel(8'd255, 8'd0, '1, '0);
      send_pixel(8'd1, 8'd0, '1, '1);
      send_pixel(8'd0, 8'd0, '1, '1);
      send_pixel(8'd0, 8'd255, '1, '0);
      send_pixel(8'd7, 8'd9, {16'h1234, 16'hffff, 16'h0000, 16'h8000}, '1);
      settle();

      // coefficient one gives the destination nothing
      write_reg(REG_MIX_COEFF, 256);
      send_pixel(8'd0, 8'd255, '1, '0);
      send_pixel(8'd255, 8'd255, '1, '0);
      send_pixel(8'd200, 8'd0, {4{16'h00ff}}, '1);
      settle();

      // coefficient above one saturates, count above four mixes all, count zero mixes none
      write_reg(REG_MIX_COEFF, 511);
      write_reg(REG_CHANNEL_COUNT, 7);
      send_pixel(8'd0, 8'd200, '1, '0);
      send_pixel(8'd100, 8'd50, {4{16'hfffe}}, {4{16'h0003}});
      settle();
      write_reg(REG_CHANNEL_COUNT, 0);
      write_reg(REG_MIX_COEFF, 77);
      send_pixel(8'd100, 8'd50, '1, '0);
      send_pixel(8'd0, 8'd0, '1, '0);
      settle();

      // random phases, each with its own settings and one of four idling mixes
      for (int p = 0; p < PHASES; p++) begin
         write_reg(REG_MIX_COEFF, phase_coeff[p]);
         write_reg(REG_CHANNEL_COUNT, phase_count[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 71; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 71; end
            default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
         endcase
         // long receiver hold-off while the sender keeps offering
         if (p == 4) holdoff_wanted = 1;
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_pixel(pick_weight(), pick_weight(), pick_values(), pick_values());
         settle();
      end

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      $display("run covered %0d words over %0d register settings, coefficient 0..511, counts 0..7",
               pixels_sent, PHASES + 5);
      $display("idling: none, sender only, receiver only, both, plus one long receiver hold-off");
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/qwpm_pkg.sv
rtl/qwpm_req_if.sv
rtl/qwpm_front.sv
rtl/qwpm_div_stage.sv
rtl/quality_weighted_pixel_mixer_top.sv
dv/tb_qwpm_mix_checker.sv
dv/tb_quality_weighted_pixel_mixer_top.sv
